// File: src/grt_pkg.sv
package grt_pkg;

  // Fixed widths of the stream fields.
  localparam int HANDLE_PORT_W = 32;
  localparam int PLACED_W      = 5;
  localparam int AGE_W         = 8;
  localparam int GEN_W         = 32;
  localparam int IN_TDATA_W    = 32;
  localparam int OUT_PAD_W     = 3;
  localparam int OUT_TDATA_W   = HANDLE_PORT_W + PLACED_W + OUT_PAD_W;

  // Defaults for the top-level parameters.
  localparam int SLOTS_DEF       = 16;
  localparam int HANDLE_BITS_DEF = 32;

  localparam logic [AGE_W-1:0] AGE_LIMIT_RST = AGE_W'(4);

  typedef enum logic {
    OP_RETIRE  = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_EVICT_READ,
    ST_EVICT,
    ST_DONE
  } state_t;

endpackage

// File: src/generational_release_table_top.sv
// Generational release table. Retired handles are parked in SLOTS slots, each stamped
// with the generation current at retire time, and are handed back on the out_ stream
// once their age (generation minus stamp, modulo 2^32) reaches the age limit written
// on cfg_wr_data. An item with in_tuser = 0 retires the handle in in_tdata (handle zero
// is ignored); with in_tuser = 1 it advances the generation. Each advance and each retire
// of a nonzero handle first releases every aged handle in ascending slot order; a retire
// then takes the lowest free slot or, when the table is full, evicts the slot with the
// smallest raw stamp (lowest index on ties) and releases its handle last. Every input item
// ends with one completion item (out_tuser = 0, out_tlast = 1) that carries the slot taken,
// or SLOTS when nothing was placed. One slot RAM with a single registered read port is
// walked by a small sequencer and one shared age subtract-and-compare unit: each slot is
// read in ST_READ and judged in ST_EVAL, an eviction adds ST_EVICT_READ and ST_EVICT, and
// a stalled output can hold the walk. in_tready is high only while the sequencer is idle; a
// finished item waiting in the output register does not hold off the next input. The
// occupancy bits clear at reset, so no clearing pass over the RAM is needed.
module generational_release_table_top #(
  parameter int SLOTS       = grt_pkg::SLOTS_DEF,
  parameter int HANDLE_BITS = grt_pkg::HANDLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input stream.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [grt_pkg::IN_TDATA_W-1:0]  in_tdata,   // [31:0] handle
  input  logic                            in_tuser,   // [0] op
  // Result stream.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [grt_pkg::OUT_TDATA_W-1:0] out_tdata,  // [31:0] released_handle,
                                                      // [36:32] placed_slot, zero pad
  output logic                            out_tuser,  // [0] release_valid
  output logic                            out_tlast,  // last
  // Configuration.
  input  logic                            cfg_wr_en,
  input  logic [grt_pkg::AGE_W-1:0]       cfg_wr_data
);

  localparam int IDX_W   = $clog2(SLOTS);
  localparam int ENTRY_W = HANDLE_BITS + grt_pkg::GEN_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [grt_pkg::PLACED_W-1:0] NO_SLOT = grt_pkg::PLACED_W'(SLOTS);

  grt_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0]               idx_r, idx_nxt;
  grt_pkg::op_t                   op_r, op_nxt;
  logic [HANDLE_BITS-1:0]         hnd_r, hnd_nxt;
  logic [grt_pkg::GEN_W-1:0]      gen_r, gen_nxt;
  logic [grt_pkg::AGE_W-1:0]      age_limit_r, age_limit_nxt;
  logic [SLOTS-1:0]               occ_r, occ_nxt;
  logic                           free_found_r, free_found_nxt;
  logic [IDX_W-1:0]               free_slot_r, free_slot_nxt;
  logic [grt_pkg::GEN_W-1:0]      best_r, best_nxt;
  logic [IDX_W-1:0]               oldest_r, oldest_nxt;
  logic [grt_pkg::PLACED_W-1:0]   placed_r, placed_nxt;

  logic                               out_valid_r, out_valid_nxt;
  logic                               out_rel_r, out_rel_nxt;
  logic [grt_pkg::HANDLE_PORT_W-1:0]  out_handle_r, out_handle_nxt;
  logic [grt_pkg::PLACED_W-1:0]       out_placed_r, out_placed_nxt;
  logic                               out_last_r, out_last_nxt;

  // Slot RAM: each entry holds {stamp, handle}.
  logic               ram_wr_en;
  logic [IDX_W-1:0]   ram_wr_addr;
  logic [ENTRY_W-1:0] ram_wr_data;
  logic [IDX_W-1:0]   ram_rd_addr;
  logic [ENTRY_W-1:0] ram_rd_data;

  grt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  logic [HANDLE_BITS-1:0]    ent_handle;
  logic [grt_pkg::GEN_W-1:0] ent_stamp;
  logic [grt_pkg::GEN_W-1:0] ent_age;
  logic                      ent_occ;
  logic                      ent_aged;
  logic                      can_emit;
  logic                      accept;
  logic [HANDLE_BITS-1:0]    in_handle;

  assign ent_handle = ram_rd_data[HANDLE_BITS-1:0];
  assign ent_stamp  = ram_rd_data[HANDLE_BITS +: grt_pkg::GEN_W];
  assign ent_occ    = occ_r[idx_r];

  // The one shared age unit: subtract and compare against the limit.
  assign ent_age  = gen_r - ent_stamp;
  assign ent_aged = ent_occ && (ent_age >= grt_pkg::GEN_W'(age_limit_r));

  // The output register can take a new item when it is empty or being drained.
  assign can_emit  = !out_valid_r || out_tready;
  assign in_tready = (state_r == grt_pkg::ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign in_handle = HANDLE_BITS'(in_tdata);

  // The eviction victim is read at its own address; otherwise the scan index.
  assign ram_rd_addr = (state_r inside {grt_pkg::ST_EVICT_READ, grt_pkg::ST_EVICT})
                       ? oldest_r : idx_r;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    op_nxt         = op_r;
    hnd_nxt        = hnd_r;
    gen_nxt        = gen_r;
    age_limit_nxt  = cfg_wr_en ? cfg_wr_data : age_limit_r;
    occ_nxt        = occ_r;
    free_found_nxt = free_found_r;
    free_slot_nxt  = free_slot_r;
    best_nxt       = best_r;
    oldest_nxt     = oldest_r;
    placed_nxt     = placed_r;

    out_valid_nxt  = out_valid_r && !out_tready;
    out_rel_nxt    = out_rel_r;
    out_handle_nxt = out_handle_r;
    out_placed_nxt = out_placed_r;
    out_last_nxt   = out_last_r;

    ram_wr_en   = 1'b0;
    ram_wr_addr = idx_r;
    ram_wr_data = {gen_r, hnd_r};

    case (state_r)
      grt_pkg::ST_IDLE: begin
        if (accept) begin
          op_nxt         = grt_pkg::op_t'(in_tuser);
          hnd_nxt        = in_handle;
          idx_nxt        = '0;
          free_found_nxt = 1'b0;
          best_nxt       = '1;
          oldest_nxt     = '0;
          placed_nxt     = NO_SLOT;
          if (grt_pkg::op_t'(in_tuser) == grt_pkg::OP_ADVANCE) begin
            gen_nxt   = gen_r + grt_pkg::GEN_W'(1);
            state_nxt = grt_pkg::ST_READ;
          end else if (in_handle != '0) begin
            state_nxt = grt_pkg::ST_READ;
          end else begin
            state_nxt = grt_pkg::ST_DONE;
          end
        end
      end

      grt_pkg::ST_READ: begin
        state_nxt = grt_pkg::ST_EVAL;
      end

      grt_pkg::ST_EVAL: begin
        if (!ent_aged || can_emit) begin
          if (ent_aged) begin
            out_valid_nxt  = 1'b1;
            out_rel_nxt    = 1'b1;
            out_handle_nxt = grt_pkg::HANDLE_PORT_W'(ent_handle);
            out_placed_nxt = NO_SLOT;
            out_last_nxt   = 1'b0;
            occ_nxt[idx_r] = 1'b0;
          end
          if ((!ent_occ || ent_aged) && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_slot_nxt  = idx_r;
          end
          if (ent_occ && !ent_aged && (ent_stamp < best_r)) begin
            best_nxt   = ent_stamp;
            oldest_nxt = idx_r;
          end
          if (idx_r == LAST_IDX) begin
            if (op_r == grt_pkg::OP_ADVANCE) begin
              state_nxt = grt_pkg::ST_DONE;
            end else if (free_found_nxt) begin
              // Park the new handle in the lowest free slot.
              ram_wr_en              = 1'b1;
              ram_wr_addr            = free_slot_nxt;
              occ_nxt[free_slot_nxt] = 1'b1;
              placed_nxt             = grt_pkg::PLACED_W'(free_slot_nxt);
              state_nxt              = grt_pkg::ST_DONE;
            end else begin
              state_nxt = grt_pkg::ST_EVICT_READ;
            end
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = grt_pkg::ST_READ;
          end
        end
      end

      grt_pkg::ST_EVICT_READ: begin
        state_nxt = grt_pkg::ST_EVICT;
      end

      grt_pkg::ST_EVICT: begin
        if (can_emit) begin
          out_valid_nxt  = 1'b1;
          out_rel_nxt    = 1'b1;
          out_handle_nxt = grt_pkg::HANDLE_PORT_W'(ent_handle);
          out_placed_nxt = NO_SLOT;
          out_last_nxt   = 1'b0;
          ram_wr_en      = 1'b1;
          ram_wr_addr    = oldest_r;
          placed_nxt     = grt_pkg::PLACED_W'(oldest_r);
          state_nxt      = grt_pkg::ST_DONE;
        end
      end

      grt_pkg::ST_DONE: begin
        if (can_emit) begin
          out_valid_nxt  = 1'b1;
          out_rel_nxt    = 1'b0;
          out_handle_nxt = '0;
          out_placed_nxt = placed_r;
          out_last_nxt   = 1'b1;
          state_nxt      = grt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = grt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= grt_pkg::ST_IDLE;
      gen_r       <= '0;
      age_limit_r <= grt_pkg::AGE_LIMIT_RST;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gen_r       <= gen_nxt;
      age_limit_r <= age_limit_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    op_r         <= op_nxt;
    hnd_r        <= hnd_nxt;
    free_found_r <= free_found_nxt;
    free_slot_r  <= free_slot_nxt;
    best_r       <= best_nxt;
    oldest_r     <= oldest_nxt;
    placed_r     <= placed_nxt;
    out_rel_r    <= out_rel_nxt;
    out_handle_r <= out_handle_nxt;
    out_placed_r <= out_placed_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{grt_pkg::OUT_PAD_W{1'b0}}, out_placed_r, out_handle_r};
  assign out_tuser  = out_rel_r;
  assign out_tlast  = out_last_r;

endmodule

// File: src/grt_ram.sv
module grt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps

// Testbench for the generational release table.
//
// The bench drives retire and advance items into the slave stream and keeps its own model
// of the slot table. The model covers the parked handles, their stamps, the current
// generation and the age limit. Every accepted input item is run through that model at the
// edge where it is accepted. The release and completion items it predicts are queued in
// order. A monitor on the master stream pops the oldest prediction for every accepted
// result item and compares it field by field.
//
// Stimulus comes in phases:
//   - A short directed table runs first. Rows whose outcome is obvious (nothing parked
//     yet, nothing old enough to age out) carry their completion item typed in. The other
//     rows go through the model.
//   - Five random phases follow, each under its own age limit. The limits include the
//     largest value 255, the smallest nonzero value one, and zero. Each phase also has its own mix of
//     advances and retires.
// The age limit is only written while the table is drained and quiet.
module tb;

  localparam int NSLOT         = grt_pkg::SLOTS_DEF;
  localparam int CYCLE_LIMIT   = 400000;
  // Long enough for one item to visit every slot once, with margin for eviction
  // and completion.
  localparam int SETTLE_CYCLES = 2 * NSLOT + 12;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_PCT      = 26;
  localparam int REPORT_MAX    = 10;
  localparam int DIRECTED_ROWS = 25;

  // One item on the result stream, as the model predicts it.
  typedef struct packed {
    logic                         rel_valid;
    logic [31:0]                  handle;
    logic [grt_pkg::PLACED_W-1:0] slot;
    logic                         last;
  } release_item_t;

  // One row of the directed table. When typed is set, the row releases nothing and its
  // completion item carries typed_slot.
  typedef struct {
    grt_pkg::op_t                 op;
    logic [31:0]                  handle;
    bit                           typed;
    logic [grt_pkg::PLACED_W-1:0] typed_slot;
  } stim_row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [grt_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [grt_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tuser;
  logic                            out_tlast;
  logic                            cfg_wr_en;
  logic [grt_pkg::AGE_W-1:0]       cfg_wr_data;

  // Model state of the slot table.
  logic [31:0]               parked_handle [NSLOT];
  logic [31:0]               parked_stamp  [NSLOT];
  logic [31:0]               generation;
  logic [grt_pkg::AGE_W-1:0] age_limit_model;

  release_item_t pending_results[$];
  int            failures;
  int            cycles;

  // Control flags shared with the result sink.
  // calm switches off all random idling. hold_req asks for one long receiver hold-off.
  bit calm;
  bit hold_req;

  generational_release_table_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Runaway guard. A hung block ends the run here.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Model of the table.
  // ---------------------------------------------------------------------------------------

  task automatic push_result(input bit keep, input logic rel, input logic [31:0] handle,
                             input int slot, input logic last);
    release_item_t item;
    item.rel_valid = rel;
    item.handle    = handle;
    item.slot      = grt_pkg::PLACED_W'(slot);
    item.last      = last;
    if (keep) begin
      pending_results.push_back(item);
    end
  endtask

  // Hand back every parked handle whose age has reached the limit, walking up the slots.
  // The age is generation minus stamp, taken modulo 2^32.
  task automatic release_aged(input bit keep);
    for (int i = 0; i < NSLOT; i++) begin
      if (parked_handle[i] != 0 &&
          (generation - parked_stamp[i]) >= 32'(age_limit_model)) begin
        push_result(keep, 1'b1, parked_handle[i], NSLOT, 1'b0);
        parked_handle[i] = '0;
      end
    end
  endtask

  // Advance the model by one accepted input item. When keep is clear, the model state still
  // moves, but the predicted items are dropped because the directed table supplies them.
  task automatic predict_item(input grt_pkg::op_t op, input logic [31:0] handle,
                              input bit keep);
    int          slot;
    int          oldest;
    logic [31:0] best;
    slot = NSLOT;
    if (op == grt_pkg::OP_ADVANCE) begin
      generation = generation + 32'd1;
      release_aged(keep);
    end else if (handle != 0) begin
      release_aged(keep);
      for (int i = 0; i < NSLOT; i++) begin
        if (slot == NSLOT && parked_handle[i] == 0) begin
          slot = i;
        end
      end
      // A full table evicts the smallest raw stamp, not the oldest entry.
      // A strict compare keeps the lowest index when stamps tie.
      if (slot == NSLOT) begin
        best   = '1;
        oldest = 0;
        for (int i = 0; i < NSLOT; i++) begin
          if (parked_stamp[i] < best) begin
            best   = parked_stamp[i];
            oldest = i;
          end
        end
        push_result(keep, 1'b1, parked_handle[oldest], NSLOT, 1'b0);
        slot = oldest;
      end
      parked_handle[slot] = handle;
      parked_stamp[slot]  = generation;
    end
    push_result(keep, 1'b0, 32'd0, slot, 1'b1);
  endtask

  // ---------------------------------------------------------------------------------------
  // Result side.
  // ---------------------------------------------------------------------------------------

  task automatic log_mismatch(input string why, input release_item_t want,
                              input release_item_t got);
    failures++;
    if (failures <= REPORT_MAX) begin
      $display("mismatch (%s) at cycle %0d: want rel=%0d handle=%h slot=%0d last=%0d,",
               why, cycles, want.rel_valid, want.handle, want.slot, want.last,
               " got rel=%0d handle=%h slot=%0d last=%0d",
               got.rel_valid, got.handle, got.slot, got.last);
    end
  endtask

  // Samples at the clock edge, before any flop of the block has updated, so the monitor
  // sees the values that were on the wires for the handshake.
  always @(posedge clk) begin : result_check
    release_item_t got;
    release_item_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.rel_valid = out_tuser;
      got.handle    = out_tdata[31:0];
      got.slot      = out_tdata[grt_pkg::HANDLE_PORT_W +: grt_pkg::PLACED_W];
      got.last      = out_tlast;
      if (pending_results.size() == 0) begin
        log_mismatch("no item expected", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.rel_valid !== want.rel_valid || got.handle !== want.handle ||
            got.slot !== want.slot || got.last !== want.last) begin
          log_mismatch("field differs", want, got);
        end
      end
    end
  end

  // Result sink.
  // It drops out_tready at random about a quarter of the time, except while calm is set.
  // It also holds off once for a long stretch so that the block backs up and stalls its
  // input. The hold-off is counted here, independently of the sender.
  initial begin : result_sink
    int hold_left;
    bit hold_used;
    hold_left  = 0;
    hold_used  = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_used) begin
        hold_used = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Input side.
  // ---------------------------------------------------------------------------------------

  // Offer one item and return at the edge where it is taken.
  // in_tvalid stays high when the next item follows straight on. It is only lowered in an
  // idle gap or by the caller, so it never gets two updates in the same step.
  task automatic send_item(input grt_pkg::op_t op, input logic [31:0] handle);
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= handle;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Wait until every predicted item has arrived. Then allow one item's walk for the
  // sequencer to settle, so the block is idle before the next register write.
  task automatic drain;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_age_limit(input logic [grt_pkg::AGE_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    age_limit_model = value;
  endtask

  initial begin : stimulus
    stim_row_t                 rows [DIRECTED_ROWS];
    logic [grt_pkg::AGE_W-1:0] limit;
    int                        adv_pct;
    int                        count;
    grt_pkg::op_t              op;
    logic [31:0]               handle;

    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = grt_pkg::OP_RETIRE;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    rst_n       = 1'b0;
    calm        = 0;
    hold_req    = 0;
    failures    = 0;
    generation  = '0;
    age_limit_model = grt_pkg::AGE_LIMIT_RST;
    for (int i = 0; i < NSLOT; i++) begin
      parked_handle[i] = '0;
      parked_stamp[i]  = '0;
    end

    // Directed table, run at the reset age limit of four.
    // A retire of handle zero parks nothing.
    rows[0] = '{grt_pkg::OP_RETIRE, 32'h0000_0000, 1'b1, 5'd16};
    // Extreme handles go into the lowest free slots.
    rows[1] = '{grt_pkg::OP_RETIRE, 32'hFFFF_FFFF, 1'b1, 5'd0};
    rows[2] = '{grt_pkg::OP_RETIRE, 32'h0000_0001, 1'b1, 5'd1};
    rows[3] = '{grt_pkg::OP_RETIRE, 32'h8000_0000, 1'b1, 5'd2};
    // Three advances stay below the limit, so nothing is handed back.
    rows[4] = '{grt_pkg::OP_ADVANCE, 32'h0000_0000, 1'b1, 5'd16};
    rows[5] = '{grt_pkg::OP_ADVANCE, 32'hFFFF_FFFF, 1'b1, 5'd16};
    rows[6] = '{grt_pkg::OP_ADVANCE, 32'h5A5A_A5A5, 1'b1, 5'd16};
    // The fourth advance reaches the limit and releases all three handles in slot order.
    rows[7] = '{grt_pkg::OP_ADVANCE, 32'h0000_0000, 1'b0, 5'd0};
    // Fill every slot in the same generation, so all stamps tie.
    for (int i = 0; i < NSLOT; i++) begin
      rows[8 + i] = '{grt_pkg::OP_RETIRE, 32'h1357_9BDF + 32'(i) * 32'h1111_1111, 1'b1,
                      grt_pkg::PLACED_W'(i)};
    end
    // The table is full with tied stamps, so slot zero is evicted.
    rows[24] = '{grt_pkg::OP_RETIRE, 32'h7FFF_FFFF, 1'b0, 5'd0};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[r]) begin
      send_item(rows[r].op, rows[r].handle);
      if (rows[r].typed) begin
        predict_item(rows[r].op, rows[r].handle, 1'b0);
        push_result(1'b1, 1'b0, 32'd0, int'(rows[r].typed_slot), 1'b1);
      end else begin
        predict_item(rows[r].op, rows[r].handle, 1'b1);
      end
    end
    in_tvalid <= 1'b0;
    drain();

    // Random phases. Each phase starts from a drained table and writes a new age limit.
    // The sender waits for every expected result before each write.
    //   Phase 0: the largest limit with few advances, so the table fills and evicts often.
    //   Phase 1: the smallest nonzero limit, so no handle outlives one advance.
    //   Phase 2: a limit of zero, where every parked handle is released on every advance and nonzero retire.
    //   Phase 3: a small random limit, with no idling on either side.
    //   Phase 4: a random limit from 1 to 255, with one long hold-off on the result side.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          limit = 8'd255; adv_pct = 10; count = 30;
        end
        1: begin
          limit = 8'd1; adv_pct = 35; count = 25;
        end
        2: begin
          limit = 8'd0; adv_pct = 25; count = 20;
        end
        3: begin
          limit = grt_pkg::AGE_W'($urandom_range(2, 12)); adv_pct = 30; count = 30;
        end
        default: begin
          limit = grt_pkg::AGE_W'($urandom_range(1, 255)); adv_pct = 20; count = 30;
        end
      endcase
      write_age_limit(limit);
      calm = (phase == 3);
      if (phase == 4) begin
        hold_req = 1;
      end
      for (int n = 0; n < count; n++) begin
        if ($urandom_range(0, 99) < adv_pct) begin
          op     = grt_pkg::OP_ADVANCE;
          handle = $urandom;
        end else begin
          op     = grt_pkg::OP_RETIRE;
          handle = ($urandom_range(0, 99) < 6) ? 32'd0 : $urandom;
        end
        send_item(op, handle);
        predict_item(op, handle, 1'b1);
      end
      in_tvalid <= 1'b0;
      drain();
      calm = 0;
    end

    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
